FILE: design/sfls_pkg.sv
// shared constants, types and command codes for the sorted first/last occurrence search
package sfls_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int INDEX_W     = 11;

  typedef logic        [1:0]             command_t;
  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [INDEX_W-1:0]     index_t;
  typedef logic        [CNT_W-1:0]       count_t;
  typedef logic        [ADDR_W-1:0]      addr_t;
  // search bounds: one extra bit so that hi can sit at -1
  typedef logic signed [CNT_W:0]         bound_t;

  localparam command_t CMD_CLEAR  = 2'd0;
  localparam command_t CMD_APPEND = 2'd1;
  localparam command_t CMD_QUERY  = 2'd2;

  localparam index_t INDEX_NONE = '1;

  typedef struct packed {
    logic   start;
    value_t target;
    count_t count;
  } search_req_t;

  typedef struct packed {
    logic   valid;
    logic   found;
    index_t first;
    index_t last;
  } search_res_t;

endpackage

FILE: design/sfls_if.sv
// item and result channel interfaces
interface sfls_req_if;
  import sfls_pkg::*;
  logic     valid;
  logic     ready;
  command_t command;
  value_t   element_value;
  value_t   target_value;

  modport source (output valid, command, element_value, target_value, input ready);
  modport sink (input valid, command, element_value, target_value, output ready);
endinterface

interface sfls_rsp_if;
  import sfls_pkg::*;
  logic   valid;
  logic   ready;
  logic   found;
  index_t first_index;
  index_t last_index;

  modport source (output valid, found, first_index, last_index, input ready);
  modport sink (input valid, found, first_index, last_index, output ready);
endinterface

FILE: design/sorted_first_last_occurrence_search_core.sv
// Sorted first/last occurrence search: takes clear, append and query items on req and
// returns one result on rsp for each query.
//
// req carries command, element_value and target_value; an item is taken when valid and
// ready are both high. Clear and append finish in the cycle they are taken and give no
// result; an append to a full store is dropped. Unused command codes are ignored.
// A query runs a binary search over the loaded entries in a single-port-read memory
// for the lowest hit and, only if there is one, a second for the highest hit. Each
// probe is a read then a compare, and each search ends with one closing step; a search
// makes at most ceil(log2(count + 1)) probes.
// req.ready stays low while a query is under way. The finished result sits in an output
// register; while rsp is stalled the next item can be taken, but a further query holds
// its result until the register frees up.
// Reset empties the store (count to zero) and drops any pending result; the store
// contents are not cleared and need no sweep.
module sorted_first_last_occurrence_search_core (
  input logic       clk,
  input logic       rst,
  sfls_req_if.sink  req,
  sfls_rsp_if.source rsp
);
  import sfls_pkg::*;

  count_t      count;
  logic        accept;
  logic        full;
  logic        we;
  logic        re;
  addr_t       raddr;
  value_t      rdata;
  search_req_t sreq;
  search_res_t sres;
  logic        sidle;
  logic        res_take;

  assign accept   = req.valid && req.ready;
  assign full     = (count == count_t'(STORE_DEPTH));
  assign req.ready = sidle;
  assign we       = accept && (req.command == CMD_APPEND) && !full;
  assign res_take = sres.valid && (!rsp.valid || rsp.ready);

  assign sreq.start  = accept && (req.command == CMD_QUERY);
  assign sreq.target = req.target_value;
  assign sreq.count  = count;

  sfls_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (req.element_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  sfls_search u_search (
    .clk      (clk),
    .rst      (rst),
    .req      (sreq),
    .idle     (sidle),
    .raddr    (raddr),
    .re       (re),
    .rdata    (rdata),
    .res      (sres),
    .res_take (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      case (req.command)
        CMD_CLEAR:  count <= '0;
        CMD_APPEND: if (!full) begin
          count <= count + count_t'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_take) begin
      rsp.valid       <= 1'b1;
      rsp.found       <= sres.found;
      rsp.first_index <= sres.first;
      rsp.last_index  <= sres.last;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // loaded count never passes the store depth
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(STORE_DEPTH))
    else $error("count beyond depth");

  // a query taken always starts the search engine from idle
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    sreq.start |=> !sidle)
    else $error("query did not start search");

  // store is never written while a search is running
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    !sidle |-> !we)
    else $error("store written during search");

endmodule

FILE: design/sfls_ram.sv
// element store: one write port, one registered read port
module sfls_ram (
  input  logic           clk,
  input  logic           we,
  input  sfls_pkg::addr_t  waddr,
  input  sfls_pkg::value_t wdata,
  input  logic           re,
  input  sfls_pkg::addr_t  raddr,
  output sfls_pkg::value_t rdata
);
  import sfls_pkg::*;

  value_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sfls_search.sv
// binary search sequencer: lowest hit, then highest hit if there was one; each probe is a read then a compare
module sfls_search (
  input  logic                  clk,
  input  logic                  rst,
  input  sfls_pkg::search_req_t req,
  output logic                  idle,
  output sfls_pkg::addr_t       raddr,
  output logic                  re,
  input  sfls_pkg::value_t      rdata,
  output sfls_pkg::search_res_t res,
  input  logic                  res_take
);
  import sfls_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_WAIT, S_DONE} state_t;

  state_t state;
  logic   want_last;
  bound_t lo;
  bound_t hi;
  bound_t mid;
  bound_t top;
  index_t hit;
  value_t target;
  count_t count;
  bound_t mid_next;
  logic   res_found;
  index_t res_first;
  index_t res_last;

  assign mid_next = lo + ((hi - lo) >>> 1);
  assign top      = bound_t'({1'b0, count}) - bound_t'(1);
  assign idle     = (state == S_IDLE);
  assign re       = (state == S_PROBE) && (lo <= hi);
  assign raddr    = mid_next[ADDR_W-1:0];
  assign res      = {(state == S_DONE), res_found, res_first, res_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      want_last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            target    <= req.target;
            count     <= req.count;
            lo        <= '0;
            hi        <= bound_t'({1'b0, req.count}) - bound_t'(1);
            hit       <= INDEX_NONE;
            want_last <= 1'b0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo <= hi) begin
            mid   <= mid_next;
            state <= S_WAIT;
          end else if (!want_last) begin
            res_first <= hit;
            res_found <= (hit != INDEX_NONE);
            if (hit == INDEX_NONE) begin
              res_last <= INDEX_NONE;
              state    <= S_DONE;
            end else begin
              lo        <= '0;
              hi        <= top;
              hit       <= INDEX_NONE;
              want_last <= 1'b1;
            end
          end else begin
            res_last <= hit;
            state    <= S_DONE;
          end
        end
        S_WAIT: begin
          if (rdata == target) begin
            hit <= index_t'(mid);
            if (want_last) begin
              lo <= mid + bound_t'(1);
            end else begin
              hi <= mid - bound_t'(1);
            end
          end else if (rdata < target) begin
            lo <= mid + bound_t'(1);
          end else begin
            hi <= mid - bound_t'(1);
          end
          state <= S_PROBE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // probe address lies inside the live window
  a_mid_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (mid >= lo && mid <= hi))
    else $error("probe outside search window");

  // window never leaves the loaded entries
  a_window_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_WAIT) |-> (lo >= 0 && hi <= top))
    else $error("search window beyond loaded count");

  // a miss reports both indices as none
  a_miss_codes: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !res.found) |-> (res.first == INDEX_NONE && res.last == INDEX_NONE))
    else $error("miss with index set");

  // a hit on the first search has a real first index
  a_hit_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.found) |-> (res.first != INDEX_NONE))
    else $error("hit without first index");

  // a memory read is always followed by its compare cycle
  a_read_then_wait: assert property (@(posedge clk) disable iff (rst)
    re |=> (state == S_WAIT))
    else $error("read data not consumed");

endmodule

FILE: tb/sorted_first_last_occurrence_search_core_test.sv
// self-checking testbench for the sorted first/last occurrence search core
module sorted_first_last_occurrence_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sfls_pkg::*;

  localparam command_t CMD_UNUSED = 2'd3;
  localparam value_t   VALUE_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t   VALUE_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic   found;
    index_t first;
    index_t last;
  } answer_t;

  logic clk;
  logic rst;

  sfls_req_if req ();
  sfls_rsp_if rsp ();

  sorted_first_last_occurrence_search_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  value_t  model_store [STORE_DEPTH];
  int      model_count;
  answer_t awaited_answers [$];
  int      error_count;
  int      sent_items;
  bit      quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) return VALUE_MIN;
    if (r < 8) return VALUE_MAX;
    if (r < 11) return '0;
    if (r < 14) return '1;
    return value_t'($urandom());
  endfunction

  // binary search over the loaded entries, lowest or highest hit
  function automatic int locate_target(value_t t, bit want_last);
    int lo;
    int hi;
    int mid;
    int hit;
    lo  = 0;
    hi  = model_count - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (model_store[mid] == t) begin
        hit = mid;
        if (want_last) lo = mid + 1;
        else hi = mid - 1;
      end else if (model_store[mid] < t) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return hit;
  endfunction

  function automatic answer_t search_occurrences(value_t t);
    answer_t a;
    int      first;
    int      last;
    first = locate_target(t, 1'b0);
    last  = -1;
    if (first != -1) last = locate_target(t, 1'b1);
    a.found = (first != -1);
    a.first = first[INDEX_W-1:0];
    a.last  = last[INDEX_W-1:0];
    return a;
  endfunction

  function automatic void apply_item(command_t c, value_t ev, value_t tv);
    case (c)
      CMD_CLEAR: model_count = 0;
      CMD_APPEND: begin
        if (model_count < STORE_DEPTH) begin
          model_store[model_count] = ev;
          model_count++;
        end
      end
      CMD_QUERY: awaited_answers.push_back(search_occurrences(tv));
      default: ;
    endcase
  endfunction

  function automatic value_t pick_target();
    int r;
    r = $urandom_range(99);
    if (model_count > 0 && r < 45) return model_store[$urandom_range(model_count - 1)];
    if (model_count > 0 && r < 70)
      return model_store[$urandom_range(model_count - 1)] + ($urandom_range(1) ? 1 : -1);
    return rand_value();
  endfunction

  task automatic send_item(command_t c, value_t ev, value_t tv);
    int gap;
    req.valid         <= 1'b1;
    req.command       <= c;
    req.element_value <= ev;
    req.target_value  <= tv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    apply_item(c, ev, tv);
    sent_items++;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding query answer
  task automatic drain_answers();
    req.valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls and the field-by-field check
  initial begin : result_side
    int      stall;
    answer_t exp;
    rsp.ready = 1'b0;
    stall     = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (awaited_answers.size() == 0) begin
          $error("result with no query waiting");
          error_count++;
        end else begin
          exp = awaited_answers.pop_front();
          if (rsp.found !== exp.found) begin
            $error("found: expected %0d, actual %0d", exp.found, rsp.found);
            error_count++;
          end
          if (rsp.first_index !== exp.first) begin
            $error("first_index: expected %0d, actual %0d", exp.first, rsp.first_index);
            error_count++;
          end
          if (rsp.last_index !== exp.last) begin
            $error("last_index: expected %0d, actual %0d", exp.last, rsp.last_index);
            error_count++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(3) == 0) begin
        stall = pick_gap();
        rsp.ready <= (stall == 0);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_store();
    send_item(CMD_CLEAR, VALUE_MAX, VALUE_MIN);
    send_item(CMD_QUERY, '0, '0);
    send_item(CMD_QUERY, VALUE_MIN, VALUE_MAX);
    drain_answers();
  endtask

  task automatic test_single_entry();
    send_item(CMD_APPEND, VALUE_MIN, '0);
    send_item(CMD_QUERY, '0, VALUE_MIN);
    send_item(CMD_QUERY, '0, VALUE_MAX);
    send_item(CMD_QUERY, '1, '0);
    drain_answers();
  endtask

  task automatic test_extremes();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_APPEND, VALUE_MIN, '1);
    send_item(CMD_APPEND, VALUE_MIN, '0);
    send_item(CMD_APPEND, '0, '0);
    send_item(CMD_APPEND, VALUE_MAX, '0);
    send_item(CMD_APPEND, VALUE_MAX, '0);
    send_item(CMD_QUERY, '0, VALUE_MIN);
    send_item(CMD_QUERY, '0, VALUE_MAX);
    send_item(CMD_QUERY, '1, '0);
    send_item(CMD_QUERY, '0, value_t'(1));
    drain_answers();
  endtask

  // unused command code must leave the store alone
  task automatic test_unused_command();
    send_item(CMD_UNUSED, VALUE_MIN, VALUE_MIN);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_QUERY, '0, VALUE_MAX);
    drain_answers();
  endtask

  // out-of-order appends: each search still follows the probe sequence
  task automatic test_unsorted_store();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_APPEND, value_t'(5), '0);
    send_item(CMD_APPEND, value_t'(3), '0);
    send_item(CMD_APPEND, value_t'(9), '0);
    send_item(CMD_APPEND, value_t'(3), '0);
    send_item(CMD_QUERY, '0, value_t'(3));
    send_item(CMD_QUERY, '0, value_t'(5));
    drain_answers();
  endtask

  task automatic test_store_full();
    longint v;
    send_item(CMD_CLEAR, '0, '0);
    v = longint'(VALUE_MIN);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      send_item(CMD_APPEND, value_t'(v), rand_value());
      if ($urandom_range(3) != 0) v += $urandom_range(1, 1 << 22);
      if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
    end
    // store is full: these appends are dropped
    send_item(CMD_APPEND, VALUE_MIN, '0);
    send_item(CMD_APPEND, '0, '0);
    send_item(CMD_APPEND, VALUE_MAX, '0);
    send_item(CMD_QUERY, '0, VALUE_MIN);
    send_item(CMD_QUERY, '0, model_store[STORE_DEPTH-1]);
    send_item(CMD_QUERY, '0, model_store[STORE_DEPTH/2]);
    send_item(CMD_QUERY, '0, VALUE_MAX);
    send_item(CMD_QUERY, '0, '0);
    repeat (6) send_item(CMD_QUERY, rand_value(), pick_target());
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_QUERY, '0, VALUE_MIN);
    drain_answers();
  endtask

  // random traffic until the whole run reaches its item budget
  task automatic test_random_sequences();
    int     start;
    int     n;
    bit     narrow;
    bit     drained;
    longint v;
    start   = sent_items;
    drained = 1'b0;
    while (sent_items < 1150) begin
      quiet = ($urandom_range(9) == 0);
      if ($urandom_range(99) < 80) begin
        // mostly a fresh sorted load followed by queries
        if ($urandom_range(9) != 0) send_item(CMD_CLEAR, rand_value(), rand_value());
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 16);
        narrow = $urandom_range(1);
        if (narrow) v = int'($urandom_range(16)) - 8;
        else if ($urandom_range(7) == 0) v = longint'(VALUE_MIN);
        else v = longint'(rand_value());
        for (int i = 0; i < n; i++) begin
          send_item(CMD_APPEND, value_t'(v), rand_value());
          if (narrow) v += $urandom_range(2);
          else if ($urandom_range(2) != 0) v += $urandom_range(1, 1 << 24);
          if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
        end
        repeat ($urandom_range(1, 6)) send_item(CMD_QUERY, rand_value(), pick_target());
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(command_t'($urandom_range(3)), rand_value(), pick_target());
      end
      if (!drained && 2 * (sent_items - start) > 1150 - start) begin
        drain_answers();
        drained = 1'b1;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : main_flow
    int waited;
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.command       = CMD_CLEAR;
    req.element_value = '0;
    req.target_value  = '0;
    error_count       = 0;
    sent_items        = 0;
    model_count       = 0;
    quiet             = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_single_entry();
    test_extremes();
    test_unused_command();
    test_unsorted_store();
    test_store_full();
    test_random_sequences();

    req.valid <= 1'b0;
    waited = 0;
    while (awaited_answers.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $error("%0d query answers never arrived", awaited_answers.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
